[rtl/mieu_pkg.sv]
`default_nettype none
package mieu_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int MD_STEPS = 64;

   localparam logic [63:0] RESET_PC = 64'h0000_0000_1fc0_0000;
   localparam logic [63:0] EXC_VECTOR = 64'h0000_0000_1fc0_0380;

   typedef logic [5:0] op_type;

   localparam op_type OP_SLL    = 6'd0;
   localparam op_type OP_SRL    = 6'd1;
   localparam op_type OP_SRA    = 6'd2;
   localparam op_type OP_JR     = 6'd3;
   localparam op_type OP_SYSCALL = 6'd4;
   localparam op_type OP_BREAK  = 6'd5;
   localparam op_type OP_MFHI   = 6'd6;
   localparam op_type OP_MTHI   = 6'd7;
   localparam op_type OP_MFLO   = 6'd8;
   localparam op_type OP_MTLO   = 6'd9;
   localparam op_type OP_MULT   = 6'd10;
   localparam op_type OP_MULTU  = 6'd11;
   localparam op_type OP_DIV    = 6'd12;
   localparam op_type OP_DIVU   = 6'd13;
   localparam op_type OP_ADD    = 6'd14;
   localparam op_type OP_AND    = 6'd15;
   localparam op_type OP_OR     = 6'd16;
   localparam op_type OP_XOR    = 6'd17;
   localparam op_type OP_NOR    = 6'd18;
   localparam op_type OP_SLT    = 6'd19;
   localparam op_type OP_SLTU   = 6'd20;
   localparam op_type OP_BLTZ   = 6'd21;
   localparam op_type OP_BGEZ   = 6'd22;
   localparam op_type OP_BLTZAL = 6'd23;
   localparam op_type OP_BGEZAL = 6'd24;
   localparam op_type OP_J      = 6'd25;
   localparam op_type OP_JAL    = 6'd26;
   localparam op_type OP_BEQ    = 6'd27;
   localparam op_type OP_BNE    = 6'd28;
   localparam op_type OP_ADDI   = 6'd29;
   localparam op_type OP_SLTI   = 6'd30;
   localparam op_type OP_SLTIU  = 6'd31;
   localparam op_type OP_LUI    = 6'd32;
   localparam op_type OP_LW     = 6'd33;
   localparam op_type OP_LB     = 6'd34;
   localparam op_type OP_SW     = 6'd35;
   localparam op_type OP_SB     = 6'd36;
   localparam op_type OP_UNIMP  = 6'd37;
   localparam op_type OP_LDRET  = 6'd38;

   localparam logic [2:0] MEM_NONE    = 3'd0;
   localparam logic [2:0] MEM_RD_WORD = 3'd1;
   localparam logic [2:0] MEM_RD_BYTE = 3'd2;
   localparam logic [2:0] MEM_WR_WORD = 3'd3;
   localparam logic [2:0] MEM_WR_BYTE = 3'd4;

   localparam logic [1:0] EXC_NONE     = 2'd0;
   localparam logic [1:0] EXC_SYS_TRAP = 2'd1;
   localparam logic [1:0] EXC_BRK_TRAP = 2'd2;
   localparam logic [1:0] EXC_UNIMP    = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [31:0] load_data;
   } item_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage
`default_nettype wire

[rtl/mieu_front.sv]
`default_nettype none
module mieu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_command,
   input  wire logic [31:0]       req_instr_word,
   input  wire logic [31:0]       req_load_data,
   output logic                   push,
   output mieu_pkg::item_type     push_item,
   input  wire logic              full
);
   import mieu_pkg::*;

   function automatic op_type classify(input logic cmd, input logic [31:0] w);
      op_type r;
      r = OP_UNIMP;
      if (cmd) begin
         r = OP_LDRET;
      end else begin
         case (w[31:26]) inside
            6'h00: begin
               case (w[5:0])
                  6'h00: r = OP_SLL;
                  6'h02: r = OP_SRL;
                  6'h03: r = OP_SRA;
                  6'h08: r = OP_JR;
                  6'h0C: r = OP_SYSCALL;
                  6'h0D: r = OP_BREAK;
                  6'h10: r = OP_MFHI;
                  6'h11: r = OP_MTHI;
                  6'h12: r = OP_MFLO;
                  6'h13: r = OP_MTLO;
                  6'h18: r = OP_MULT;
                  6'h19: r = OP_MULTU;
                  6'h1A: r = OP_DIV;
                  6'h1B: r = OP_DIVU;
                  6'h20: r = OP_ADD;
                  6'h24: r = OP_AND;
                  6'h25: r = OP_OR;
                  6'h26: r = OP_XOR;
                  6'h27: r = OP_NOR;
                  6'h2A: r = OP_SLT;
                  6'h2B: r = OP_SLTU;
                  default: r = OP_UNIMP;
               endcase
            end
            6'h01: begin
               case (w[20:16])
                  5'h00: r = OP_BLTZ;
                  5'h01: r = OP_BGEZ;
                  5'h10: r = OP_BLTZAL;
                  5'h11: r = OP_BGEZAL;
                  default: r = OP_UNIMP;
               endcase
            end
            6'h02: r = OP_J;
            6'h03: r = OP_JAL;
            6'h04: r = OP_BEQ;
            6'h05: r = OP_BNE;
            6'h08, 6'h09: r = OP_ADDI;
            6'h0A: r = OP_SLTI;
            6'h0B: r = OP_SLTIU;
            6'h0F: r = OP_LUI;
            6'h20: r = OP_LB;
            6'h23: r = OP_LW;
            6'h28: r = OP_SB;
            6'h2B: r = OP_SW;
            default: r = OP_UNIMP;
         endcase
      end
      return r;
   endfunction

   assign req_ready = !full && !reset;
   assign push = req_valid && req_ready;

   always_comb begin
      push_item.op = classify(req_command, req_instr_word);
      push_item.word = req_instr_word;
      push_item.load_data = req_load_data;
   end

   // ready must be low during reset
   assert property (@(posedge clock) reset |-> !push)
      else $error("push during reset");

endmodule
`default_nettype wire

[rtl/mieu_queue.sv]
`default_nettype none
module mieu_queue #(
   parameter int Depth = mieu_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mieu_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output mieu_pkg::item_type      pop_item,
   output logic                    empty
);
   import mieu_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   item_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = (count_ff == CntFull);
   assign empty = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule
`default_nettype wire

[rtl/mieu_back.sv]
`default_nettype none
module mieu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               empty,
   input  wire mieu_pkg::item_type pop_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_pc_now,
   output logic [2:0]              rsp_mem_kind,
   output logic [63:0]             rsp_mem_addr,
   output logic [31:0]             rsp_mem_wdata,
   output logic [1:0]              rsp_exception_code,
   output logic                    rsp_load_waiting
);
   import mieu_pkg::*;

   localparam int CntW = $clog2(MD_STEPS);
   localparam logic [CntW-1:0] CntLast = CntW'(MD_STEPS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_MFIX = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DFIX = 3'd5;

   logic [2:0] state_ff, state_in;
   item_type cur_ff;

   logic [63:0] gpr_mem [32];
   logic [31:0] vld_ff;
   logic [63:0] rd_a_ff, rd_b_ff;
   logic va_ff, vb_ff;

   logic [63:0] pc_ff, hi_ff, lo_ff;
   logic [4:0] pend_dest_ff;
   logic pend_byte_ff, pend_valid_ff;

   logic [63:0] hacc_ff, lacc_ff, mcand_ff, corr_ff;
   logic neg_q_ff, neg_r_ff;
   logic [CntW-1:0] cnt_ff;

   logic rsp_valid_ff;
   logic [63:0] rsp_pc_ff, rsp_addr_ff;
   logic [2:0] rsp_kind_ff;
   logic [31:0] rsp_wdata_ff;
   logic [1:0] rsp_exc_ff;
   logic rsp_lw_ff;

   // execute-stage signals
   logic [31:0] w;
   logic [63:0] a, b, imm, pc4, branch, addsum;
   logic [18:0] off19;
   logic [4:0] sa;
   logic [63:0] next_pc, wr_data, addr;
   logic [4:0] wr_addr;
   logic wr_req, wr_en;
   logic [2:0] kind;
   logic [31:0] wdata;
   logic [1:0] exc;
   logic emit, go_mul, go_div, md_signed;
   logic hi_we, lo_we;
   logic [63:0] hi_new, lo_new, mul_corr, ua, ub;
   logic pend_set, pend_clr, pend_after;

   // shared multiply/divide step
   logic [64:0] msum;
   logic [64:0] dshift;
   logic [65:0] ddiff;
   logic dge;

   assign pop = (state_ff == S_IDLE) && !empty && !rsp_valid_ff;

   assign w = cur_ff.word;
   assign a = va_ff ? rd_a_ff : '0;
   assign b = vb_ff ? rd_b_ff : '0;
   assign sa = w[10:6];
   assign imm = {{48{w[15]}}, w[15:0]};
   assign pc4 = pc_ff + 64'd4;
   assign off19 = {w[15], w[15:0], 2'b00} + 19'd4;
   assign branch = pc_ff + {{45{off19[18]}}, off19};
   assign addsum = a + imm;
   assign md_signed = (cur_ff.op == OP_MULT) || (cur_ff.op == OP_DIV);
   assign mul_corr = (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
   assign ua = (md_signed && a[63]) ? (64'd0 - a) : a;
   assign ub = (md_signed && b[63]) ? (64'd0 - b) : b;

   always_comb begin
      next_pc = pc4;
      kind = MEM_NONE;
      addr = '0;
      wdata = '0;
      exc = EXC_NONE;
      wr_req = 1'b0;
      wr_addr = w[15:11];
      wr_data = '0;
      emit = 1'b1;
      go_mul = 1'b0;
      go_div = 1'b0;
      hi_we = 1'b0;
      lo_we = 1'b0;
      hi_new = a;
      lo_new = a;
      pend_set = 1'b0;
      pend_clr = 1'b0;
      if (cur_ff.op == OP_LDRET) begin
         next_pc = pc_ff;
         if (pend_valid_ff) begin
            wr_req = 1'b1;
            wr_addr = pend_dest_ff;
            wr_data = pend_byte_ff ? {{56{cur_ff.load_data[7]}}, cur_ff.load_data[7:0]}
                                   : {{32{cur_ff.load_data[7]}}, swap32(cur_ff.load_data)};
            pend_clr = 1'b1;
         end
      end else if (pend_valid_ff) begin
         // instruction dropped while a load is outstanding
         next_pc = pc_ff;
      end else begin
         case (cur_ff.op)
            OP_SLL: begin wr_req = 1'b1; wr_data = b << sa; end
            OP_SRL: begin wr_req = 1'b1; wr_data = b >> sa; end
            OP_SRA: begin wr_req = 1'b1; wr_data = 64'($signed(b) >>> sa); end
            OP_JR: next_pc = a;
            OP_SYSCALL: begin exc = EXC_SYS_TRAP; next_pc = EXC_VECTOR; end
            OP_BREAK: begin exc = EXC_BRK_TRAP; next_pc = EXC_VECTOR; end
            OP_MFHI: begin wr_req = 1'b1; wr_data = hi_ff; end
            OP_MTHI: hi_we = 1'b1;
            OP_MFLO: begin wr_req = 1'b1; wr_data = lo_ff; end
            OP_MTLO: lo_we = 1'b1;
            OP_MULT, OP_MULTU: begin emit = 1'b0; go_mul = 1'b1; end
            OP_DIV, OP_DIVU: begin
               if (b != 64'd0) begin
                  emit = 1'b0;
                  go_div = 1'b1;
               end
            end
            OP_ADD: begin wr_req = 1'b1; wr_data = a + b; end
            OP_AND: begin wr_req = 1'b1; wr_data = a & b; end
            OP_OR: begin wr_req = 1'b1; wr_data = a | b; end
            OP_XOR: begin wr_req = 1'b1; wr_data = a ^ b; end
            OP_NOR: begin wr_req = 1'b1; wr_data = ~(a | b); end
            OP_SLT: begin
               wr_req = 1'b1;
               wr_data = {63'd0, $signed(a) < $signed(b)};
            end
            OP_SLTU: begin wr_req = 1'b1; wr_data = {63'd0, a < b}; end
            OP_BLTZ: if (a[63]) next_pc = branch;
            OP_BGEZ: if (!a[63]) next_pc = branch;
            OP_BLTZAL: begin
               wr_req = 1'b1; wr_addr = 5'd31; wr_data = pc4;
               if (a[63]) next_pc = branch;
            end
            OP_BGEZAL: begin
               wr_req = 1'b1; wr_addr = 5'd31; wr_data = pc4;
               if (!a[63]) next_pc = branch;
            end
            OP_J: next_pc = {pc_ff[63:28], w[25:0], 2'b00};
            OP_JAL: begin
               wr_req = 1'b1; wr_addr = 5'd31; wr_data = pc4;
               next_pc = {pc_ff[63:28], w[25:0], 2'b00};
            end
            OP_BEQ: if (a == b) next_pc = branch;
            OP_BNE: if (a != b) next_pc = branch;
            OP_ADDI: begin wr_req = 1'b1; wr_addr = w[20:16]; wr_data = addsum; end
            OP_SLTI: begin
               wr_req = 1'b1; wr_addr = w[20:16];
               wr_data = {63'd0, $signed(a) < $signed(imm)};
            end
            OP_SLTIU: begin
               wr_req = 1'b1; wr_addr = w[20:16];
               wr_data = {63'd0, a < imm};
            end
            OP_LUI: begin
               wr_req = 1'b1; wr_addr = w[20:16];
               wr_data = {{32{w[15]}}, w[15:0], 16'd0};
            end
            OP_LW: begin kind = MEM_RD_WORD; addr = addsum; pend_set = 1'b1; end
            OP_LB: begin kind = MEM_RD_BYTE; addr = addsum; pend_set = 1'b1; end
            OP_SW: begin kind = MEM_WR_WORD; addr = addsum; wdata = swap32(b[31:0]); end
            OP_SB: begin kind = MEM_WR_BYTE; addr = addsum; wdata = {24'd0, b[7:0]}; end
            default: exc = EXC_UNIMP;
         endcase
      end
      pend_after = (pend_valid_ff && !pend_clr) || pend_set;
   end

   assign wr_en = (state_ff == S_EXEC) && wr_req && (wr_addr != 5'd0);

   assign msum = {1'b0, hacc_ff} + (lacc_ff[0] ? {1'b0, mcand_ff} : 65'd0);
   assign dshift = {hacc_ff, lacc_ff[63]};
   assign ddiff = {1'b0, dshift} - {2'b00, mcand_ff};
   assign dge = !ddiff[65];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (pop) state_in = S_EXEC;
         S_EXEC: begin
            if (go_mul) state_in = S_MUL;
            else if (go_div) state_in = S_DIV;
            else state_in = S_IDLE;
         end
         S_MUL: if (cnt_ff == CntLast) state_in = S_MFIX;
         S_DIV: if (cnt_ff == CntLast) state_in = S_DFIX;
         S_MFIX: state_in = S_IDLE;
         S_DFIX: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // register file with registered reads at the queue head
   always_ff @(posedge clock) begin
      rd_a_ff <= gpr_mem[pop_item.word[25:21]];
      rd_b_ff <= gpr_mem[pop_item.word[20:16]];
      if (wr_en) begin
         gpr_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_item;
      end
      case (state_ff)
         S_EXEC: begin
            cnt_ff <= '0;
            corr_ff <= (cur_ff.op == OP_MULT) ? mul_corr : 64'd0;
            neg_q_ff <= md_signed && (a[63] ^ b[63]);
            neg_r_ff <= md_signed && a[63];
            hacc_ff <= '0;
            if (go_mul) begin
               lacc_ff <= b;
               mcand_ff <= a;
            end else begin
               lacc_ff <= ua;
               mcand_ff <= ub;
            end
         end
         S_MUL: begin
            cnt_ff <= cnt_ff + 1'b1;
            hacc_ff <= msum[64:1];
            lacc_ff <= {msum[0], lacc_ff[63:1]};
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + 1'b1;
            hacc_ff <= dge ? ddiff[63:0] : dshift[63:0];
            lacc_ff <= {lacc_ff[62:0], dge};
         end
         default: ;
      endcase
      if (state_ff == S_EXEC && emit) begin
         rsp_pc_ff <= next_pc;
         rsp_kind_ff <= kind;
         rsp_addr_ff <= addr;
         rsp_wdata_ff <= wdata;
         rsp_exc_ff <= exc;
         rsp_lw_ff <= pend_after;
      end else if (state_ff == S_MFIX || state_ff == S_DFIX) begin
         rsp_pc_ff <= pc_ff;
         rsp_kind_ff <= MEM_NONE;
         rsp_addr_ff <= '0;
         rsp_wdata_ff <= '0;
         rsp_exc_ff <= EXC_NONE;
         rsp_lw_ff <= pend_valid_ff;
      end
      if (state_ff == S_EXEC && pend_set) begin
         pend_dest_ff <= w[20:16];
         pend_byte_ff <= (cur_ff.op == OP_LB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         pc_ff <= RESET_PC;
         hi_ff <= '0;
         lo_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         va_ff <= vld_ff[pop_item.word[25:21]];
         vb_ff <= vld_ff[pop_item.word[20:16]];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == S_EXEC) begin
            pc_ff <= next_pc;
            pend_valid_ff <= pend_after;
            if (hi_we) hi_ff <= hi_new;
            if (lo_we) lo_ff <= lo_new;
         end
         if (state_ff == S_MFIX) begin
            hi_ff <= hacc_ff - corr_ff;
            lo_ff <= lacc_ff;
         end
         if (state_ff == S_DFIX) begin
            lo_ff <= neg_q_ff ? (64'd0 - lacc_ff) : lacc_ff;
            hi_ff <= neg_r_ff ? (64'd0 - hacc_ff) : hacc_ff;
         end
         if ((state_ff == S_EXEC && emit) || state_ff == S_MFIX || state_ff == S_DFIX) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pc_now = rsp_pc_ff;
   assign rsp_mem_kind = rsp_kind_ff;
   assign rsp_mem_addr = rsp_addr_ff;
   assign rsp_mem_wdata = rsp_wdata_ff;
   assign rsp_exception_code = rsp_exc_ff;
   assign rsp_load_waiting = rsp_lw_ff;

   assert property (@(posedge clock) disable iff (reset) pop |-> !rsp_valid_ff)
      else $error("item started while result slot busy");
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC && emit) || state_ff == S_MFIX || state_ff == S_DFIX)
      |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");
   assert property (@(posedge clock) disable iff (reset) wr_en |-> (wr_addr != 5'd0))
      else $error("write to r0");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && cnt_ff == CntLast) |=> (state_ff == S_MFIX))
      else $error("multiply did not finish after last step");

endmodule
`default_nettype wire

[rtl/mips_integer_execute_unit.sv]
`default_nettype none
// MIPS integer execute unit: each item on the req_ channel is either an instruction word
// (command 0) or the data for an outstanding load (command 1), and gives exactly one item
// on the rsp_ channel with the new pc, any bus request and any exception code. A front
// end decodes items into a small queue, so the input keeps accepting while the back end
// works or a result waits, until the queue is full. The back end registers its reads of
// the 32-entry register file as it takes an item from the queue and executes the item in
// the next cycle; MULT/MULTU/DIV/DIVU then go through a shared radix-2 multiply/divide
// unit of 64 steps plus a correction state (a DIV/DIVU by zero skips it). A load leaves
// load_waiting set and later instructions are dropped until its return item arrives.
module mips_integer_execute_unit #(
   parameter int QueueDepth = mieu_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [31:0] req_instr_word,
   input  wire logic [31:0] req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_pc_now,
   output logic [2:0]       rsp_mem_kind,
   output logic [63:0]      rsp_mem_addr,
   output logic [31:0]      rsp_mem_wdata,
   output logic [1:0]       rsp_exception_code,
   output logic             rsp_load_waiting
);
   import mieu_pkg::*;

   // decoded items between front and back
   logic push, full, pop, empty;
   item_type push_item, pop_item;

   mieu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_instr_word (req_instr_word),
      .req_load_data  (req_load_data),
      .push           (push),
      .push_item      (push_item),
      .full           (full)
   );

   // short queue so front and back stall independently
   mieu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   // execution, architectural state and result register
   mieu_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pc_now         (rsp_pc_now),
      .rsp_mem_kind       (rsp_mem_kind),
      .rsp_mem_addr       (rsp_mem_addr),
      .rsp_mem_wdata      (rsp_mem_wdata),
      .rsp_exception_code (rsp_exception_code),
      .rsp_load_waiting   (rsp_load_waiting)
   );

endmodule
`default_nettype wire
